FILE: src/accel_motion_change_detector_assert.svh
// Assertion macros for the motion change detector.
// Expects clk_i and rst_ni in the scope of use.
`ifndef ACCEL_MOTION_CHANGE_DETECTOR_ASSERT_SVH
`define ACCEL_MOTION_CHANGE_DETECTOR_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define AMCD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define AMCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/amcd_pkg.sv
// Shared types, widths and defaults for the motion change detector.
// No dependencies.
package amcd_pkg;

  localparam int AxisW     = 16;
  localparam int BaseW     = 17;
  localparam int AbsW      = 17;
  localparam int DevW      = 18;
  localparam int ThreshW   = 17;
  localparam int CalibW    = 5;
  localparam int CfgDataW  = 17;
  localparam int CfgIdxW   = 1;
  localparam int EventSeqW = 32;
  localparam int NumAxes   = 3;

  localparam int MaxCalibDef = 16;
  localparam int SeqBitsDef  = 32;

  localparam logic [ThreshW-1:0] ThreshReset = ThreshW'(2000);
  localparam logic [CalibW-1:0]  CalibReset  = CalibW'(10);

  localparam logic [CfgIdxW-1:0] RegThreshold = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegCalibCnt  = CfgIdxW'(1);

  typedef struct packed {
    logic signed [AxisW-1:0] accel_x_mg;
    logic signed [AxisW-1:0] accel_y_mg;
    logic signed [AxisW-1:0] accel_z_mg;
    logic                    sample_ok;
  } amcd_in_t;

  typedef struct packed {
    logic [EventSeqW-1:0] event_seq;
    logic                 motion_active;
    logic [DevW-1:0]      dev_sum_mg;
  } amcd_out_t;

  // Per-lane control from the sequencer.
  typedef struct packed {
    logic sample_ld;
    logic cal_add;
    logic div_load;
    logic div_step;
    logic div_last;
    logic div_zero;
    logic dev_en;
  } amcd_lane_ctrl_t;

  // Calibration sum width: one sign bit of headroom over the sample count.
  function automatic int amcd_sum_w(input int max_calib);
    return AxisW + 1 + $clog2(max_calib);
  endfunction

endpackage

FILE: src/accel_motion_change_detector.sv
// Top level of the motion change detector: config registers, sequencer, lanes, merge.
// Depends on amcd_pkg, amcd_lane, amcd_merge and the assertion header.
//
//   port group   dir  handshake               payload
//   in_*         in   in_valid_i/in_ready_o   amcd_in_t
//   out_*        out  out_valid_o/out_ready_i amcd_out_t
//   cfg_*        in   cfg_we_i                cfg_idx_i, cfg_data_i
//
// A calibration item leaves the sequencer in S_IDLE; the item that ends calibration also passes
// through S_LOAD and S_DIV, where the bit-serial baseline divider forms all SumW quotient bits.
// A monitored good sample passes through latch (S_IDLE), lane deviation (S_DEV) and merge (S_EVAL);
// the merge waits while an earlier result has not been transferred.
// A failed sample after calibration leaves the sequencer in S_IDLE. Reset is asynchronous.
module accel_motion_change_detector import amcd_pkg::*; #(
  parameter int MaxCalib = MaxCalibDef,
  parameter int SeqBits  = SeqBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  amcd_in_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output amcd_out_t           out_data_o
);

  localparam int CntW  = $clog2(MaxCalib + 1);
  localparam int SumW  = amcd_sum_w(MaxCalib);
  localparam int StepW = $clog2(SumW);
  localparam int TgtW  = (CntW > CalibW) ? CntW : CalibW;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LOAD = 5'b00010,
    S_DIV  = 5'b00100,
    S_DEV  = 5'b01000,
    S_EVAL = 5'b10000
  } amcd_state_e;

  amcd_state_e         state_q, state_d;
  logic [ThreshW-1:0]  thresh_q;
  logic [CalibW-1:0]   calib_q;
  logic [CntW-1:0]     attempts_q, attempts_d;
  logic [CntW-1:0]     good_q, good_d;
  logic [StepW-1:0]    step_q, step_d;
  logic                calib_done_q, calib_done_d;

  logic                accept;
  logic                merge_free;
  logic                eval;
  logic [TgtW-1:0]     cfg_n;
  logic [TgtW-1:0]     target;
  logic [TgtW-1:0]     attempts_nx;
  amcd_lane_ctrl_t     lane_ctrl;

  logic signed [AxisW-1:0]          axis_in [NumAxes];
  logic [NumAxes-1:0][AbsW-1:0]     lane_abs;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Clamp the calibration count into 1..MaxCalib.
  always_comb begin
    cfg_n = TgtW'(calib_q);
    if (cfg_n == '0) begin
      target = TgtW'(1);
    end else if (cfg_n > TgtW'(MaxCalib)) begin
      target = TgtW'(MaxCalib);
    end else begin
      target = cfg_n;
    end
    attempts_nx = TgtW'(attempts_q) + TgtW'(1);
  end

  always_comb begin
    state_d      = state_q;
    attempts_d   = attempts_q;
    good_d       = good_q;
    step_d       = step_q;
    calib_done_d = calib_done_q;
    eval         = 1'b0;
    lane_ctrl    = '0;
    lane_ctrl.div_zero = (good_q == '0);
    unique case (state_q)
      S_IDLE: begin
        lane_ctrl.sample_ld = accept;
        if (accept) begin
          if (!calib_done_q) begin
            lane_ctrl.cal_add = in_data_i.sample_ok;
            if (in_data_i.sample_ok) begin
              good_d = good_q + CntW'(1);
            end
            attempts_d = CntW'(attempts_nx);
            if (attempts_nx >= target) begin
              state_d = S_LOAD;
            end
          end else if (in_data_i.sample_ok) begin
            state_d = S_DEV;
          end
        end
      end
      S_LOAD: begin
        lane_ctrl.div_load = 1'b1;
        step_d             = '0;
        state_d            = S_DIV;
      end
      S_DIV: begin
        lane_ctrl.div_step = 1'b1;
        if (step_q == StepW'(SumW - 1)) begin
          lane_ctrl.div_last = 1'b1;
          calib_done_d       = 1'b1;
          state_d            = S_IDLE;
        end else begin
          step_d = step_q + StepW'(1);
        end
      end
      S_DEV: begin
        lane_ctrl.dev_en = 1'b1;
        state_d          = S_EVAL;
      end
      S_EVAL: begin
        // Hold until the output register can take a new result.
        if (merge_free) begin
          eval    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      attempts_q   <= '0;
      good_q       <= '0;
      step_q       <= '0;
      calib_done_q <= 1'b0;
      thresh_q     <= ThreshReset;
      calib_q      <= CalibReset;
    end else begin
      state_q      <= state_d;
      attempts_q   <= attempts_d;
      good_q       <= good_d;
      step_q       <= step_d;
      calib_done_q <= calib_done_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegThreshold: thresh_q <= cfg_data_i[ThreshW-1:0];
          RegCalibCnt:  calib_q  <= cfg_data_i[CalibW-1:0];
          default: ;
        endcase
      end
    end
  end

  assign axis_in[0] = in_data_i.accel_x_mg;
  assign axis_in[1] = in_data_i.accel_y_mg;
  assign axis_in[2] = in_data_i.accel_z_mg;

  for (genvar g = 0; g < NumAxes; g++) begin : g_lane
    amcd_lane #(
      .MaxCalib (MaxCalib)
    ) u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (lane_ctrl),
      .sample_i  (axis_in[g]),
      .divisor_i (good_q),
      .abs_dev_o (lane_abs[g])
    );
  end

  amcd_merge #(
    .SeqBits (SeqBits)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .eval_i      (eval),
    .thresh_i    (thresh_q),
    .abs_i       (lane_abs),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .free_o      (merge_free)
  );

  `include "accel_motion_change_detector_assert.svh"

  `AMCD_ASSERT_NOW(a_no_result_in_calib, !calib_done_q, !out_valid_o, "result during calibration")
  `AMCD_ASSERT_NOW(a_div_only_in_calib, state_q == S_DIV, !calib_done_q, "divider ran after calibration")
  `AMCD_ASSERT_NOW(a_done_from_div, $rose(calib_done_q), $past(state_q) == S_DIV, "calibration ended outside divider")
  `AMCD_ASSERT_NEXT(a_load_then_div, state_q == S_LOAD, state_q == S_DIV, "divider load not followed by steps")

endmodule

FILE: src/amcd_lane.sv
// One axis lane: calibration sum, serial baseline divider, abs deviation.
// Depends on amcd_pkg.
module amcd_lane import amcd_pkg::*; #(
  parameter int MaxCalib = MaxCalibDef,
  localparam int CntW    = $clog2(MaxCalib + 1),
  localparam int SumW    = amcd_sum_w(MaxCalib)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  amcd_lane_ctrl_t         ctrl_i,
  input  logic signed [AxisW-1:0] sample_i,
  input  logic [CntW-1:0]         divisor_i,
  output logic [AbsW-1:0]         abs_dev_o
);

  logic signed [SumW-1:0]  sum_q, sum_d;
  logic signed [BaseW-1:0] base_q, base_d;
  logic signed [AxisW-1:0] sample_q;
  logic [SumW-1:0]         quo_q, quo_d;
  logic [CntW-1:0]         rem_q, rem_d;
  logic                    neg_q;
  logic [AbsW-1:0]         abs_q;

  logic [SumW-1:0]         sum_mag;
  logic [CntW:0]           rem_sh;
  logic                    quo_bit;
  logic [BaseW-1:0]        quo_low;
  logic signed [DevW-1:0]  diff;

  assign sum_mag = sum_q[SumW-1] ? SumW'(-sum_q) : SumW'(sum_q);

  // Restoring division, one quotient bit per step.
  always_comb begin
    rem_sh  = {rem_q, quo_q[SumW-1]};
    quo_bit = (rem_sh >= {1'b0, divisor_i});
    rem_d   = quo_bit ? CntW'(rem_sh - {1'b0, divisor_i}) : rem_sh[CntW-1:0];
    quo_d   = {quo_q[SumW-2:0], quo_bit};
    quo_low = quo_d[BaseW-1:0];
    if (ctrl_i.div_zero) begin
      base_d = '0;
    end else if (neg_q) begin
      base_d = -$signed(quo_low);
    end else begin
      base_d = $signed(quo_low);
    end
  end

  always_comb begin
    sum_d = sum_q;
    if (ctrl_i.cal_add) begin
      sum_d = sum_q + SumW'(sample_i);
    end
  end

  assign diff = DevW'(sample_q) - DevW'(base_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      base_q <= '0;
    end else begin
      sum_q <= sum_d;
      if (ctrl_i.div_step && ctrl_i.div_last) begin
        base_q <= base_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.sample_ld) begin
      sample_q <= sample_i;
    end
    if (ctrl_i.div_load) begin
      quo_q <= sum_mag;
      rem_q <= '0;
      neg_q <= sum_q[SumW-1];
    end else if (ctrl_i.div_step) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
    if (ctrl_i.dev_en) begin
      abs_q <= diff[DevW-1] ? AbsW'(-diff) : AbsW'(diff);
    end
  end

  assign abs_dev_o = abs_q;

endmodule

FILE: src/amcd_merge.sv
// Merge stage: sums lane deviations, thresholds, tracks state, holds the result.
// Depends on amcd_pkg.
module amcd_merge import amcd_pkg::*; #(
  parameter int SeqBits = SeqBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          eval_i,
  input  logic [ThreshW-1:0]            thresh_i,
  input  logic [NumAxes-1:0][AbsW-1:0]  abs_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output amcd_out_t                     out_data_o,
  output logic                          free_o
);

  logic               state_q;
  logic [SeqBits-1:0] seq_q, seq_d;
  logic               valid_q;
  amcd_out_t          out_q;

  logic [DevW-1:0]    dev;
  logic               next_state;
  logic               change;

  assign dev        = DevW'(abs_i[0]) + DevW'(abs_i[1]) + DevW'(abs_i[2]);
  assign next_state = (dev > DevW'(thresh_i));
  assign change     = eval_i && (next_state != state_q);
  assign seq_d      = seq_q + SeqBits'(1);
  assign free_o     = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= 1'b0;
      seq_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (change) begin
        state_q <= next_state;
        seq_q   <= seq_d;
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (change) begin
      out_q.event_seq     <= EventSeqW'(seq_d);
      out_q.motion_active <= next_state;
      out_q.dev_sum_mg    <= dev;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: sim/tb.sv
// Testbench for accel_motion_change_detector: directed table, then random samples, mostly around the baseline.
// Checks every result transfer against given values or the in-bench predictor. Depends on amcd_pkg and the RTL.
`timescale 1ns / 100ps

module tb;
  import amcd_pkg::*;

  localparam int IdleCycles = 48;
  // Baseline formed by the directed calibration rows below:
  // x 762/4, y -32669/4, z -12/4, each truncated toward zero.
  localparam int BaseX = 190;
  localparam int BaseY = -8167;
  localparam int BaseZ = -3;

  typedef enum logic {ROW_CFG, ROW_SMP} row_kind_e;
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_GIVEN} chk_e;

  typedef struct {
    row_kind_e            kind;
    logic [CfgIdxW-1:0]   idx;
    logic [CfgDataW-1:0]  data;
    amcd_in_t             smp;
    chk_e                 chk;
    amcd_out_t            want;
  } row_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  amcd_in_t            in_data_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  amcd_out_t           out_data_o;

  accel_motion_change_detector u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #2 clk_i = ~clk_i;

  // Predictor state
  logic [ThreshW-1:0] thr_mg    = ThreshReset;
  logic [CalibW-1:0]  cal_len   = CalibReset;
  int                 cal_tries = 0;
  int                 cal_good  = 0;
  int                 cal_sum[NumAxes];
  int                 base_mg[NumAxes];
  bit                 cal_done  = 1'b0;
  bit                 motion_now = 1'b0;
  logic [EventSeqW-1:0] event_cnt = '0;

  amcd_out_t pending_events[$];
  row_t      stim_rows[$];
  int        mism       = 0;
  int        stall_left = 0;
  bit        no_idle    = 1'b0;

  initial begin
    for (int i = 0; i < NumAxes; i++) begin
      cal_sum[i] = 0;
      base_mg[i] = 0;
    end
  end

  function automatic bit predict_motion_event(input amcd_in_t s, output amcd_out_t ev);
    int ax[NumAxes];
    int dev;
    int d;
    int tgt;
    bit nxt;
    ev = '0;
    ax[0] = $signed(s.accel_x_mg);
    ax[1] = $signed(s.accel_y_mg);
    ax[2] = $signed(s.accel_z_mg);
    if (!cal_done) begin
      if (s.sample_ok) begin
        for (int i = 0; i < NumAxes; i++) cal_sum[i] += ax[i];
        cal_good++;
      end
      cal_tries++;
      // clamp the attempt count into 1..MaxCalib
      tgt = (cal_len == 0) ? 1 : ((cal_len > MaxCalibDef) ? MaxCalibDef : int'(cal_len));
      if (cal_tries >= tgt) begin
        for (int i = 0; i < NumAxes; i++)
          base_mg[i] = (cal_good == 0) ? 0 : cal_sum[i] / cal_good;
        cal_done = 1'b1;
      end
      return 1'b0;
    end
    if (!s.sample_ok) return 1'b0;
    dev = 0;
    for (int i = 0; i < NumAxes; i++) begin
      d = ax[i] - base_mg[i];
      dev += (d < 0) ? -d : d;
    end
    nxt = (dev > int'(thr_mg));
    if (nxt == motion_now) return 1'b0;
    motion_now = nxt;
    event_cnt  = event_cnt + 1'b1;
    ev.event_seq     = event_cnt;
    ev.motion_active = nxt;
    ev.dev_sum_mg    = DevW'(dev);
    return 1'b1;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic amcd_in_t mk_smp(input int x, input int y, input int z, input bit ok);
    amcd_in_t s;
    s.accel_x_mg = AxisW'(x);
    s.accel_y_mg = AxisW'(y);
    s.accel_z_mg = AxisW'(z);
    s.sample_ok  = ok;
    return s;
  endfunction

  task automatic add_cfg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    row_t r;
    r.kind = ROW_CFG;
    r.idx  = idx;
    r.data = data;
    r.smp  = '0;
    r.chk  = CHK_NONE;
    r.want = '0;
    stim_rows.push_back(r);
  endtask

  task automatic add_smp(input int x, input int y, input int z, input bit ok, input chk_e chk,
                         input int seq = 0, input bit act = 0, input int dev = 0);
    row_t r;
    r.kind = ROW_SMP;
    r.idx  = '0;
    r.data = '0;
    r.smp  = mk_smp(x, y, z, ok);
    r.chk  = chk;
    r.want.event_seq     = EventSeqW'(seq);
    r.want.motion_active = act;
    r.want.dev_sum_mg    = DevW'(dev);
    stim_rows.push_back(r);
  endtask

  // Drop valid, drain results, then let the block settle before a register write.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (IdleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    wait_idle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    if (idx == RegThreshold) thr_mg = data[ThreshW-1:0];
    else if (idx == RegCalibCnt) cal_len = data[CalibW-1:0];
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Returns at the edge where the sample transfers; valid is left high.
  task automatic send_sample(input amcd_in_t s);
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= s;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Result side: check transfers, then stall at random.
  always @(posedge clk_i) begin : out_side
    amcd_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_events.size() == 0) begin
        if (mism < 10)
          $display("unexpected result: seq %0d active %0b dev %0d", out_data_o.event_seq,
                   out_data_o.motion_active, out_data_o.dev_sum_mg);
        mism++;
      end else begin
        want = pending_events.pop_front();
        if (out_data_o.event_seq !== want.event_seq ||
            out_data_o.motion_active !== want.motion_active ||
            out_data_o.dev_sum_mg !== want.dev_sum_mg) begin
          if (mism < 10)
            $display("mismatch: exp seq %0d active %0b dev %0d, got seq %0d active %0b dev %0d",
                     want.event_seq, want.motion_active, want.dev_sum_mg,
                     out_data_o.event_seq, out_data_o.motion_active, out_data_o.dev_sum_mg);
          mism++;
        end
      end
    end
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_ready_i <= 1'b1;
      if ($urandom_range(0, 9) == 0) stall_left = pick_gap();
    end
  end

  initial begin : stim
    amcd_out_t ev;
    amcd_in_t  s;
    bit        hit;
    int        thr;
    int        cnt;
    int        r;
    int        lim;
    int        v[NumAxes];
    int        bs[NumAxes];

    // Calibration at the widest count, then cut short mid-phase.
    add_cfg(RegCalibCnt, '1);
    add_smp(32767, -32768, 0, 1'b1, CHK_NONE);
    add_smp(-32000, 100, -7, 1'b1, CHK_NONE);
    add_smp(12345, -1, 1000, 1'b0, CHK_NONE);
    add_smp(-5, -32768, -3, 1'b1, CHK_NONE);
    add_smp(0, 32767, -2, 1'b1, CHK_NONE);
    add_cfg(RegCalibCnt, '0);
    add_smp(-1, -1, -1, 1'b0, CHK_NONE);
    // Count rewritten after calibration: no effect.
    add_cfg(RegCalibCnt, CfgDataW'(5));
    // Reset threshold, strictly-greater boundary.
    add_smp(BaseX, BaseY, BaseZ, 1'b1, CHK_NONE);
    add_smp(BaseX + 2001, BaseY, BaseZ, 1'b1, CHK_GIVEN, 1, 1'b1, 2001);
    add_smp(BaseX + 2000, BaseY, BaseZ, 1'b1, CHK_GIVEN, 2, 1'b0, 2000);
    add_smp(-32768, 32767, 32767, 1'b0, CHK_NONE);
    add_cfg(RegThreshold, '0);
    add_smp(BaseX + 1, BaseY, BaseZ, 1'b1, CHK_GIVEN, 3, 1'b1, 1);
    add_smp(BaseX, BaseY, BaseZ, 1'b1, CHK_GIVEN, 4, 1'b0, 0);
    add_smp(-32768, 32767, 32767, 1'b1, CHK_MODEL);
    add_smp(32767, -32768, -32768, 1'b1, CHK_MODEL);
    add_cfg(RegThreshold, '1);
    add_smp(-32768, 32767, 32767, 1'b1, CHK_MODEL);
    add_smp(32767, -32768, -32768, 1'b1, CHK_MODEL);
    add_smp(BaseX, BaseY, BaseZ, 1'b1, CHK_MODEL);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_CFG) begin
        write_reg(stim_rows[i].idx, stim_rows[i].data);
      end else begin
        send_sample(stim_rows[i].smp);
        hit = predict_motion_event(stim_rows[i].smp, ev);
        if (stim_rows[i].chk == CHK_GIVEN) pending_events.push_back(stim_rows[i].want);
        else if (stim_rows[i].chk == CHK_MODEL && hit) pending_events.push_back(ev);
      end
    end

    bs[0] = base_mg[0];
    bs[1] = base_mg[1];
    bs[2] = base_mg[2];
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        1:       thr = 0;
        2:       thr = 1;
        4:       thr = 131071;
        5:       thr = $urandom_range(0, 131071);
        7:       thr = 2000;
        default: thr = $urandom_range(100, 4000);
      endcase
      write_reg(RegThreshold, CfgDataW'(thr));
      if (ph == 3 || ph == 6) write_reg(RegCalibCnt, CfgDataW'($urandom_range(0, 131071)));
      cnt = 0;
      while (cnt < 82) begin
        if ($urandom_range(0, 49) == 0) no_idle = !no_idle;
        r = $urandom_range(0, 99);
        if (r < 25) begin
          // raw bit patterns; some are failed reads
          s.accel_x_mg = AxisW'($urandom);
          s.accel_y_mg = AxisW'($urandom);
          s.accel_z_mg = AxisW'($urandom);
          s.sample_ok  = (r >= 10);
        end else begin
          // straddle the threshold so the state keeps flipping
          lim = thr * 2 / 3 + 3;
          for (int a = 0; a < NumAxes; a++) begin
            v[a] = $urandom_range(0, lim);
            if ($urandom_range(0, 1)) v[a] = -v[a];
            v[a] += bs[a];
          end
          s = mk_smp(v[0], v[1], v[2], 1'b1);
        end
        send_sample(s);
        hit = predict_motion_event(s, ev);
        if (hit) pending_events.push_back(ev);
        if (s.sample_ok) cnt++;
      end
    end

    wait_idle();
    if (mism == 0 && pending_events.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("tb NOT OK");
    $finish;
  end

endmodule
